// ===== rtl/core/vtm_pkg.sv =====
// Package for the virtual timer multiplexer: operation codes, status codes,
// register indexes and default values. No dependencies.
`default_nettype none
package vtm_pkg;
  localparam int unsigned NumGuestsDef = 4;
  localparam int unsigned NumHartsDef  = 4;
  localparam int unsigned IdxW         = 2;
  localparam int unsigned CfgAddrW     = 1;
  localparam int unsigned CfgDataW     = 32;
  localparam logic [31:0] DefaultIntervalRst = 32'd2000000;
  localparam logic [9:0]  ResumeOverheadRst  = 10'd50;

  typedef enum logic [2:0] {
    KIND_ARM     = 3'd0,
    KIND_RESCHED = 3'd1,
    KIND_IRQ     = 3'd2,
    KIND_SUSPEND = 3'd3,
    KIND_RESUME  = 3'd4,
    KIND_READ    = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_TGT   = 2'd1,
    STATUS_MISMATCH = 2'd2
  } status_e;

  localparam logic [CfgAddrW-1:0] REG_DEFAULT_INTERVAL = 1'd0;
  localparam logic [CfgAddrW-1:0] REG_RESUME_OVERHEAD  = 1'd1;

  // Flag word layout of one entry: {retry, scheduled}.
  typedef struct packed {
    logic retry;
    logic sched;
  } flags_t;
endpackage
`default_nettype wire

// ===== rtl/core/vtm_ram.sv =====
// Generic single-port-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module vtm_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/core/virtual_timer_multiplexer_core.sv =====
// Virtual timer multiplexer: entry table in RAMs, sequencer and compare logic.
// Depends on vtm_pkg and vtm_ram.
// Sequence: arm/suspend/read/interrupt pass READ, EXEC and DONE; resume adds
// RES2 between READ and EXEC; reschedule passes READ, a one-entry-per-cycle
// scan through the deadline, offset and flag RAMs followed by a registered
// compare, then DONE. One command at a time; busy is high from start to
// result strobe. Reset: async, active low. After reset a clearing pass writes
// zero into every entry; busy is high during it. The receiver cannot stall.
`default_nettype none
module virtual_timer_multiplexer_core
  import vtm_pkg::*;
#(
  parameter int unsigned NumGuests = NumGuestsDef,
  parameter int unsigned NumHarts  = NumHartsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [2:0]          kind_i,
  input  wire logic [IdxW-1:0]     guest_index_i,
  input  wire logic [IdxW-1:0]     hart_index_i,
  input  wire logic [63:0]         now_i,
  input  wire logic [63:0]         deadline_i,
  input  wire logic                delivered_i,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgAddrW-1:0] cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output logic                     done_o,
  output logic [63:0]              compare_value_o,
  output logic                     interrupt_enabled_o,
  output logic                     target_valid_o,
  output logic [IdxW-1:0]          target_guest_o,
  output logic [IdxW-1:0]          target_hart_o,
  output logic [63:0]              virtual_time_o,
  output logic [1:0]               status_o
);
  localparam int unsigned Entries = NumGuests * NumHarts;
  localparam int unsigned AW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned GW = (NumGuests > 1) ? $clog2(NumGuests) : 1;
  localparam int unsigned HW = (NumHarts > 1) ? $clog2(NumHarts) : 1;
  localparam logic [AW:0] LastEntry = (AW + 1)'(Entries - 1);
  localparam logic [AW:0] ScanEnd   = (AW + 1)'(Entries);
  localparam logic [HW-1:0] LastHart = HW'(NumHarts - 1);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_READ  = 7'b0000100,
    ST_EXEC  = 7'b0001000,
    ST_RES2  = 7'b0010000,
    ST_SCAN  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [31:0] interval_q;
  logic [9:0]  overhead_q;

  logic [2:0]  kind_q;
  logic [GW-1:0] g_q;
  logic [HW-1:0] h_q;
  logic        inside_q;
  logic [63:0] now_q, dl_q;
  logic        deliv_q;
  logic [AW-1:0] addr_q;

  logic [63:0] cmp_q;
  logic        ien_q;
  logic        tv_q;
  logic [GW-1:0] tg_q;
  logic [HW-1:0] th_q;
  logic [63:0] vt_q;
  logic [1:0]  st_q;
  logic        done_q;

  logic [AW:0] cnt_q;
  logic [GW-1:0] cnt_g_q;
  logic [HW-1:0] cnt_h_q;
  logic        scan_v_q;
  logic [GW-1:0] scan_g_q;
  logic [HW-1:0] scan_h_q;
  logic [63:0] sum_q;
  logic        sum_v_q;
  logic [GW-1:0] sum_g_q;
  logic [HW-1:0] sum_h_q;
  flags_t      sum_f_q;

  // RAM ports
  logic          dl_we, off_we, stp_we, fl_we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0]   dl_wd, off_wd, stp_wd;
  flags_t        fl_wd;
  logic [63:0]   dl_rd, off_rd, stp_rd;
  flags_t        fl_rd;
  logic [63:0]   tmp_q;

  vtm_ram #(.Width(64), .Depth(Entries)) u_dl (
    .clk_i, .we_i(dl_we), .waddr_i(waddr), .wdata_i(dl_wd),
    .raddr_i(raddr), .rdata_o(dl_rd));
  vtm_ram #(.Width(64), .Depth(Entries)) u_off (
    .clk_i, .we_i(off_we), .waddr_i(waddr), .wdata_i(off_wd),
    .raddr_i(raddr), .rdata_o(off_rd));
  vtm_ram #(.Width(64), .Depth(Entries)) u_stp (
    .clk_i, .we_i(stp_we), .waddr_i(waddr), .wdata_i(stp_wd),
    .raddr_i(raddr), .rdata_o(stp_rd));
  vtm_ram #(.Width(2), .Depth(Entries)) u_fl (
    .clk_i, .we_i(fl_we), .waddr_i(waddr), .wdata_i(fl_wd),
    .raddr_i(raddr), .rdata_o(fl_rd));

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  logic          in_inside;
  logic [AW:0]   in_addr;
  assign in_inside = (32'(guest_index_i) < NumGuests) && (32'(hart_index_i) < NumHarts);
  assign in_addr   = (AW + 1)'(32'(guest_index_i) * NumHarts + 32'(hart_index_i));

  logic scan_last;
  logic scan_end;
  assign scan_last = (cnt_q == LastEntry);
  assign scan_end  = (cnt_q == ScanEnd);

  always_comb begin
    raddr = (state_q == ST_SCAN) ? cnt_q[AW-1:0] : addr_q;
    if (accept) raddr = in_addr[AW-1:0];
  end

  always_comb begin
    state_d = state_q;
    dl_we = 1'b0; off_we = 1'b0; stp_we = 1'b0; fl_we = 1'b0;
    waddr = addr_q;
    dl_wd = dl_q; off_wd = tmp_q; stp_wd = now_q;
    fl_wd = fl_rd;
    unique case (state_q)
      ST_CLEAR: begin
        waddr = cnt_q[AW-1:0];
        dl_we = 1'b1; off_we = 1'b1; stp_we = 1'b1; fl_we = 1'b1;
        dl_wd = '0; off_wd = '0; stp_wd = '0; fl_wd = '0;
        if (scan_last) state_d = ST_IDLE;
      end
      ST_IDLE: if (accept) state_d = ST_READ;
      ST_READ: begin
        // RAM read data is valid this cycle.
        if (kind_q == KIND_RESCHED) state_d = ST_SCAN;
        else if (kind_q == KIND_RESUME && inside_q) state_d = ST_RES2;
        else state_d = ST_EXEC;
      end
      ST_RES2: state_d = ST_EXEC;
      ST_EXEC: state_d = ST_DONE;
      ST_SCAN: if (!scan_v_q && !sum_v_q && scan_end) state_d = ST_DONE;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
    if (state_q == ST_EXEC && inside_q) begin
      unique case (kind_q)
        KIND_ARM: begin
          dl_we = 1'b1; fl_we = 1'b1;
          fl_wd = '{retry: fl_rd.retry, sched: 1'b1};
        end
        KIND_SUSPEND: stp_we = 1'b1;
        KIND_RESUME:  off_we = 1'b1;
        KIND_IRQ: if (tv_q && tg_q == g_q && th_q == h_q) begin
          fl_we = 1'b1;
          fl_wd = '{retry: !deliv_q, sched: 1'b0};
        end
        default: ;
      endcase
    end
  end

  // Flags and deadlines are held in the RAM output registers through EXEC;
  // raddr keeps addr_q so the read data stays stable.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i; g_q <= GW'(guest_index_i); h_q <= HW'(hart_index_i);
      inside_q <= in_inside; now_q <= now_i; dl_q <= deadline_i;
      deliv_q <= delivered_i; addr_q <= in_inside ? in_addr[AW-1:0] : '0;
    end
    if (state_q == ST_READ) tmp_q <= now_q - stp_rd;
    if (state_q == ST_RES2) tmp_q <= off_rd + tmp_q + 64'(overhead_q);
    sum_q   <= dl_rd + off_rd;
    sum_g_q <= scan_g_q;
    sum_h_q <= scan_h_q;
    sum_f_q <= fl_rd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR; cnt_q <= '0; cnt_g_q <= '0; cnt_h_q <= '0;
      interval_q <= DefaultIntervalRst; overhead_q <= ResumeOverheadRst;
      cmp_q <= '1; ien_q <= 1'b0; tv_q <= 1'b0; tg_q <= '0; th_q <= '0;
      vt_q <= '0; st_q <= STATUS_OK; done_q <= 1'b0;
      scan_v_q <= 1'b0; sum_v_q <= 1'b0; scan_g_q <= '0; scan_h_q <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_DONE);
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_DEFAULT_INTERVAL: interval_q <= cfg_data_i;
          REG_RESUME_OVERHEAD:  overhead_q <= cfg_data_i[9:0];
          default: ;
        endcase
      end
      scan_v_q <= (state_q == ST_SCAN) && !scan_end;
      if (state_q == ST_SCAN) begin
        scan_g_q <= cnt_g_q;
        scan_h_q <= cnt_h_q;
      end
      sum_v_q  <= scan_v_q;
      unique case (state_q)
        ST_CLEAR: cnt_q <= scan_last ? '0 : cnt_q + 1'b1;
        ST_READ: begin
          cnt_q <= '0; cnt_g_q <= '0; cnt_h_q <= '0;
          vt_q <= '0; st_q <= STATUS_OK;
          if (kind_q == KIND_RESCHED) begin
            tv_q <= 1'b0; tg_q <= '0; th_q <= '0;
            cmp_q <= now_q + 64'(interval_q); ien_q <= 1'b1;
          end
          if (kind_q == KIND_READ && inside_q) vt_q <= stp_rd - off_rd;
          if (kind_q == KIND_IRQ) begin
            if (!tv_q) st_q <= STATUS_NO_TGT;
            else if (tg_q != g_q || th_q != h_q || !inside_q) st_q <= STATUS_MISMATCH;
          end
        end
        ST_SCAN: begin
          // Read address runs ahead; the sum of an entry passes the RAM output
          // register and the sum register before it is checked. Guest and hart travel with the address.
          if (!scan_end) begin
            cnt_q <= cnt_q + 1'b1;
            if (cnt_h_q == LastHart) begin
              cnt_h_q <= '0;
              cnt_g_q <= cnt_g_q + 1'b1;
            end else begin
              cnt_h_q <= cnt_h_q + 1'b1;
            end
          end
          if (sum_v_q && (sum_f_q.retry || (sum_f_q.sched && sum_q < cmp_q))) begin
            cmp_q <= sum_q; tv_q <= 1'b1;
            tg_q <= sum_g_q;
            th_q <= sum_h_q;
          end
        end
        default: ;
      endcase
    end
  end

  assign done_o              = done_q;
  assign compare_value_o     = cmp_q;
  assign interrupt_enabled_o = ien_q;
  assign target_valid_o      = tv_q;
  assign target_guest_o      = IdxW'(tg_q);
  assign target_hart_o       = IdxW'(th_q);
  assign virtual_time_o      = vt_q;
  assign status_o            = st_q;

`ifndef NO_ASSERTIONS
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> busy) else $error("scan while not busy");
  a_tgt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tv_q |-> (tg_q == '0 && th_q == '0)) else $error("stale target index");
`endif
endmodule
`default_nettype wire
